>>> rtl/bts_pkg.sv
// Shared types and constants for the blur-then-sharpen 3x3 filter.
package bts_pkg;

    // Configuration register width and reset values
    localparam int unsigned CFG_W     = 12;
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

    // Default frame size limits
    localparam int unsigned MAX_WIDTH_DEF  = 2048;
    localparam int unsigned MAX_HEIGHT_DEF = 4095;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    // Input beat commands
    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_FLUSH = 1'b1
    } t_cmd;

    // One 4-byte pixel, channel 0 in the low byte
    typedef struct packed {
        logic [7:0] extra;
        logic [7:0] ch2;
        logic [7:0] ch1;
        logic [7:0] ch0;
    } t_px;

    // One result beat
    typedef struct packed {
        t_px  px;
        logic frame_end;
    } t_res;

endpackage

>>> rtl/bts_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module bts_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = bts_pkg::MAX_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read, read data registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/bts_stage.sv
// One 3x3 window stage: two-row line buffer, window registers and the kernel.
module bts_stage #(
    parameter int unsigned MAX_WIDTH  = bts_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = bts_pkg::MAX_HEIGHT_DEF,
    parameter bit          SHARPEN    = 1'b0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_rd_col,
    input  logic                          i_valid,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_col,
    input  logic [$clog2(MAX_HEIGHT)-1:0] i_row,
    input  bts_pkg::t_px                  i_px,
    output bts_pkg::t_px                  o_res
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned RW = $clog2(MAX_HEIGHT);
    localparam int unsigned PW = $bits(bts_pkg::t_px);
    localparam int unsigned LW = 2 * PW;

    typedef bts_pkg::t_px [2:0][2:0] t_win;

    logic [LW-1:0] rd_data;
    logic [LW-1:0] line_word;
    logic [LW-1:0] wr_data;
    logic [LW-1:0] r_fwd_data;
    logic          r_fwd;
    bts_pkg::t_px  above;
    bts_pkg::t_px  mid;
    t_win          r_win;
    t_win          n_win;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    bts_pkg::t_px  filt;

    // Gaussian 1-2-1 / 2-4-2 / 1-2-1, divided by 16
    function automatic bts_pkg::t_px f_blur(t_win win);
        bts_pkg::t_px res;
        logic [11:0]  sum;
        int           ch;
        res = win[1][1];
        for (ch = 0; ch < 3; ch++) begin
            sum = 12'(win[0][0][8*ch +: 8]) + (12'(win[0][1][8*ch +: 8]) << 1)
                + 12'(win[0][2][8*ch +: 8]) + (12'(win[1][0][8*ch +: 8]) << 1)
                + (12'(win[1][1][8*ch +: 8]) << 2) + (12'(win[1][2][8*ch +: 8]) << 1)
                + 12'(win[2][0][8*ch +: 8]) + (12'(win[2][1][8*ch +: 8]) << 1)
                + 12'(win[2][2][8*ch +: 8]);
            res[8*ch +: 8] = sum[11:4];
        end
        return res;
    endfunction

    // Nine times the centre minus the eight neighbors, clamped to a byte
    function automatic bts_pkg::t_px f_sharpen(t_win win);
        bts_pkg::t_px       res;
        logic [11:0]        sum9;
        logic [11:0]        c10;
        logic signed [12:0] acc;
        int                 ch;
        res = win[1][1];
        for (ch = 0; ch < 3; ch++) begin
            sum9 = 12'(win[0][0][8*ch +: 8]) + 12'(win[0][1][8*ch +: 8])
                 + 12'(win[0][2][8*ch +: 8]) + 12'(win[1][0][8*ch +: 8])
                 + 12'(win[1][1][8*ch +: 8]) + 12'(win[1][2][8*ch +: 8])
                 + 12'(win[2][0][8*ch +: 8]) + 12'(win[2][1][8*ch +: 8])
                 + 12'(win[2][2][8*ch +: 8]);
            c10  = (12'(win[1][1][8*ch +: 8]) << 3) + (12'(win[1][1][8*ch +: 8]) << 1);
            acc  = $signed({1'b0, c10}) - $signed({1'b0, sum9});
            if (acc < 13'sd0) begin
                res[8*ch +: 8] = 8'd0;
            end else if (acc > 13'sd255) begin
                res[8*ch +: 8] = 8'd255;
            end else begin
                res[8*ch +: 8] = acc[7:0];
            end
        end
        return res;
    endfunction

    // Line buffer: each column holds {row above, previous row}
    bts_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (i_adv && i_valid),
        .i_waddr (i_col),
        .i_wdata (wr_data),
        .i_re    (i_adv),
        .i_raddr (i_rd_col),
        .o_rdata (rd_data)
    );

    // Take the forwarded column when the previous beat wrote the same address
    assign line_word = r_fwd ? r_fwd_data : rd_data;
    assign above     = bts_pkg::t_px'(line_word[LW-1 -: PW]);
    assign mid       = bts_pkg::t_px'(line_word[PW-1:0]);
    assign wr_data   = {mid, i_px};

    // Shift the window left and load the new column
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
        end
        n_win[0][2] = above;
        n_win[1][2] = mid;
        n_win[2][2] = i_px;
    end

    // Advance window and position, track the write-to-read bypass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
            r_win <= '0;
            r_col <= '0;
            r_row <= '0;
        end else if (i_adv) begin
            r_fwd <= i_valid && (i_col == i_rd_col);
            if (i_valid) begin
                r_win <= n_win;
                r_col <= i_col;
                r_row <= i_row;
            end
        end
    end

    // Hold the written column for the bypass
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_fwd_data <= wr_data;
        end
    end

    // Select the kernel
    generate
        if (SHARPEN) begin : g_sharpen
            assign filt = f_sharpen(r_win);
        end else begin : g_blur
            assign filt = f_blur(r_win);
        end
    endgenerate

    // Pass the centre through on the frame border
    assign o_res = (r_col >= CW'(2) && r_row >= RW'(2)) ? filt : r_win[1][1];

endmodule

>>> rtl/blur_then_sharpen_3x3.sv
// Top level of the two-stage 3x3 blur-then-sharpen pixel stream filter.
// Usage: pixels enter in raster order, one beat per clock; the block takes a new beat
// every cycle unless its output register and skid register are both full, and
// o_in_stall is a registered signal. Stage one blurs, stage two sharpens the blurred
// stream; each stage keeps two rows in a MAX_WIDTH-deep, 64-bit line RAM, so the
// stream is delayed by 2*W+2 beats: the first 2*W+2 pixels after a restart give no
// result, then every pixel gives one. Flush beats push the tail of a frame out, one
// result each, and restart counting once the tail is gone; a pixel arriving during a
// drain drops the tail and opens a new frame. Internally a beat passes through the pipeline
// stages (line RAM read, blur window, sharpen window) before it reaches the
// output register. The line RAMs are never cleared; border pixels never use unwritten
// columns. Write frame_width and frame_height only while the block is idle.
module blur_then_sharpen_3x3 #(
    parameter int unsigned MAX_WIDTH  = bts_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = bts_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input beats
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_command,
    input  logic [7:0]                     i_chan0_in,
    input  logic [7:0]                     i_chan1_in,
    input  logic [7:0]                     i_chan2_in,
    input  logic [7:0]                     i_extra_byte_in,
    // result beats
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [7:0]                     o_chan0_out,
    output logic [7:0]                     o_chan1_out,
    output logic [7:0]                     o_chan2_out,
    output logic [7:0]                     o_extra_byte_out,
    output logic                           o_frame_end,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bts_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned RW = $clog2(MAX_HEIGHT);
    localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned FW = $clog2(2 * MAX_WIDTH + 3);

    typedef struct packed {
        logic [CW-1:0] col;
        logic [RW-1:0] row;
    } t_pos;

    // Clamp the width register to the supported range
    function automatic logic [WW-1:0] f_clamp_w(logic [bts_pkg::CFG_W-1:0] v);
        if (v < bts_pkg::CFG_W'(3)) begin
            return WW'(3);
        end else if (32'(v) > 32'(MAX_WIDTH)) begin
            return WW'(MAX_WIDTH);
        end
        return WW'(v);
    endfunction

    // Clamp the height register to the supported range
    function automatic logic [HW-1:0] f_clamp_h(logic [bts_pkg::CFG_W-1:0] v);
        if (v < bts_pkg::CFG_W'(3)) begin
            return HW'(3);
        end else if (32'(v) > 32'(MAX_HEIGHT)) begin
            return HW'(MAX_HEIGHT);
        end
        return HW'(v);
    endfunction

    // Raster position one row and one pixel earlier, wrapping within the frame
    function automatic t_pos f_earlier(logic [CW-1:0] col, logic [RW-1:0] row,
                                       logic [WW-1:0] w, logic [HW-1:0] h);
        t_pos          p;
        logic [HW-1:0] hr;
        hr = HW'(row);
        if (col != '0) begin
            p.col = col - 1'b1;
            p.row = (row != '0) ? row - 1'b1 : RW'(h - 1'b1);
        end else begin
            p.col = CW'(w - 1'b1);
            p.row = (hr >= HW'(2)) ? RW'(hr - HW'(2)) : RW'(hr + h - HW'(2));
        end
        return p;
    endfunction

    // Configuration and derived frame geometry
    logic [bts_pkg::CFG_W-1:0] r_frame_width;
    logic [bts_pkg::CFG_W-1:0] r_frame_height;
    logic [WW-1:0]             r_w;
    logic [HW-1:0]             r_h;
    logic [FW-1:0]             r_target;

    // Input position and fill tracking
    logic [CW-1:0] r_icol, n_icol;
    logic [RW-1:0] r_irow, n_irow;
    logic [FW-1:0] r_fill, n_fill;
    logic          r_drain, n_drain;

    // Entry decode
    logic          adv;
    logic          accept;
    logic          is_flush;
    logic          go;
    logic          restart;
    logic [CW-1:0] col_w, col0;
    logic [RW-1:0] row_w, row0;
    logic [WW-1:0] col_inc;
    logic [HW-1:0] row_inc;
    logic [FW-1:0] fill_base;
    logic [FW-1:0] fill_dec;
    t_pos          mid_pos;
    t_pos          out_pos;
    logic          step_emit;
    logic          step_fe;
    bts_pkg::t_px  in_px;

    // Pipeline stages
    logic          r1_valid, r1_emit, r1_fe;
    logic [CW-1:0] r1_col, r1_mc;
    logic [RW-1:0] r1_row, r1_mr;
    bts_pkg::t_px  r1_px;
    logic          r2_valid, r2_emit, r2_fe;
    logic [CW-1:0] r2_mc;
    logic [RW-1:0] r2_mr;
    logic          r3_valid, r3_emit, r3_fe;
    bts_pkg::t_px  blur_px;
    bts_pkg::t_px  sharp_px;

    // Output register and skid
    bts_pkg::t_res res;
    logic          res_valid;
    logic          take;
    bts_pkg::t_res r_out;
    logic          r_out_valid;
    bts_pkg::t_res r_skid;
    logic          r_skid_valid;

    // Accept configuration writes at any time
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= bts_pkg::FRAME_WIDTH_RST;
            r_frame_height <= bts_pkg::FRAME_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bts_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                bts_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Register the clamped geometry and the fill target
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w      <= f_clamp_w(bts_pkg::FRAME_WIDTH_RST);
            r_h      <= f_clamp_h(bts_pkg::FRAME_HEIGHT_RST);
            r_target <= (FW'(f_clamp_w(bts_pkg::FRAME_WIDTH_RST)) << 1) + FW'(2);
        end else begin
            r_w      <= f_clamp_w(r_frame_width);
            r_h      <= f_clamp_h(r_frame_height);
            r_target <= (FW'(f_clamp_w(r_frame_width)) << 1) + FW'(2);
        end
    end

    // Advance the whole pipeline while the skid is empty
    assign adv        = !r_skid_valid;
    assign o_in_stall = r_skid_valid;
    assign accept     = i_in_valid && adv;
    assign is_flush   = (i_command == bts_pkg::CMD_FLUSH);
    assign go         = accept && !(is_flush && r_fill == '0);
    assign restart    = !is_flush && r_drain;

    // Blank pixel for flush beats
    always_comb begin
        if (is_flush) begin
            in_px = '0;
        end else begin
            in_px.ch0   = i_chan0_in;
            in_px.ch1   = i_chan1_in;
            in_px.ch2   = i_chan2_in;
            in_px.extra = i_extra_byte_in;
        end
    end

    // Decode the entering beat: positions, counters, emit and frame end
    always_comb begin
        col_w     = (WW'(r_icol) >= r_w) ? '0 : r_icol;
        row_w     = (HW'(r_irow) >= r_h) ? '0 : r_irow;
        col0      = restart ? '0 : col_w;
        row0      = restart ? '0 : row_w;
        mid_pos   = f_earlier(col0, row0, r_w, r_h);
        out_pos   = f_earlier(mid_pos.col, mid_pos.row, r_w, r_h);
        step_fe   = (WW'(out_pos.col) == r_w - WW'(1)) && (HW'(out_pos.row) == r_h - HW'(1));
        col_inc   = WW'(col0) + WW'(1);
        row_inc   = HW'(row0) + HW'(1);
        fill_base = restart ? '0 : r_fill;
        fill_dec  = r_fill - FW'(1);
        n_icol    = r_icol;
        n_irow    = r_irow;
        n_fill    = r_fill;
        n_drain   = r_drain;
        step_emit = 1'b0;
        if (go) begin
            if (col_inc >= r_w) begin
                n_icol = '0;
                n_irow = (row_inc >= r_h) ? '0 : row_inc[RW-1:0];
            end else begin
                n_icol = col_inc[CW-1:0];
                n_irow = row0;
            end
            if (is_flush) begin
                step_emit = 1'b1;
                n_fill    = fill_dec;
                n_drain   = 1'b1;
                if (fill_dec == '0) begin
                    n_icol  = '0;
                    n_irow  = '0;
                    n_drain = 1'b0;
                end
            end else begin
                n_drain = 1'b0;
                if (fill_base >= r_target) begin
                    step_emit = 1'b1;
                    n_fill    = fill_base;
                end else begin
                    n_fill = fill_base + FW'(1);
                end
            end
        end
    end

    // Update position and fill state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_icol  <= '0;
            r_irow  <= '0;
            r_fill  <= '0;
            r_drain <= 1'b0;
        end else begin
            r_icol  <= n_icol;
            r_irow  <= n_irow;
            r_fill  <= n_fill;
            r_drain <= n_drain;
        end
    end

    // Advance stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (adv) begin
            r1_valid <= go;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    // Advance stage payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_col  <= col0;
            r1_row  <= row0;
            r1_mc   <= mid_pos.col;
            r1_mr   <= mid_pos.row;
            r1_px   <= in_px;
            r1_emit <= step_emit;
            r1_fe   <= step_fe;
            r2_mc   <= r1_mc;
            r2_mr   <= r1_mr;
            r2_emit <= r1_emit;
            r2_fe   <= r1_fe;
            r3_emit <= r2_emit;
            r3_fe   <= r2_fe;
        end
    end

    // Blur stage on the input stream
    bts_stage #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .SHARPEN    (1'b0)
    ) u_blur (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_rd_col (col0),
        .i_valid  (r1_valid),
        .i_col    (r1_col),
        .i_row    (r1_row),
        .i_px     (r1_px),
        .o_res    (blur_px)
    );

    // Sharpen stage on the blurred stream
    bts_stage #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .SHARPEN    (1'b1)
    ) u_sharp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_rd_col (r1_mc),
        .i_valid  (r2_valid),
        .i_col    (r2_mc),
        .i_row    (r2_mr),
        .i_px     (blur_px),
        .o_res    (sharp_px)
    );

    // Result leaving the last stage
    assign res.px        = sharp_px;
    assign res.frame_end = r3_fe;
    assign res_valid     = r3_valid && r3_emit;
    assign take          = r_out_valid && !i_out_stall;

    // Output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (r_out_valid && !take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (res_valid) begin
            if (r_out_valid && !take) begin
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_chan0_out      = r_out.px.ch0;
    assign o_chan1_out      = r_out.px.ch1;
    assign o_chan2_out      = r_out.px.ch2;
    assign o_extra_byte_out = r_out.px.extra;
    assign o_frame_end      = r_out.frame_end;

    // The skid only fills behind a held output beat
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry without output beat");

    // A full skid freezes the pipeline
    a_skid_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |=> ($stable(r1_valid) && $stable(r2_valid) && $stable(r3_valid)))
        else $error("pipeline moved while skid full");

    // A drain is only open while tail beats remain
    a_drain_has_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain |-> (r_fill != '0))
        else $error("drain open with empty pipeline");

    // A pixel during a drain closes it
    a_pixel_ends_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && !is_flush && r_drain) |=> !r_drain)
        else $error("pixel beat did not close drain");

    // An emitted result always lands in the output register
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && res_valid) |=> r_out_valid)
        else $error("emitted result lost");

endmodule
